@@ design/amt_pkg.sv @@
package amt_pkg;

    // Motif lengths in characters and the width of the character history.
    localparam int MOTIF1_LEN = 5;
    localparam int MOTIF2_LEN = 7;
    localparam int HIST_W     = 8 * MOTIF2_LEN;
    localparam int MOTIF1_W   = 8 * MOTIF1_LEN;
    localparam int GAP_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HIST_W;

    // Register defaults.
    localparam logic [MOTIF1_W-1:0] FIRST_MOTIF_RST  = 40'd289176764739;
    localparam logic [HIST_W-1:0]   SECOND_MOTIF_RST = 56'd20056472189944660;
    localparam logic [GAP_W-1:0]    MOTIF_GAP_RST    = 7'd17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_MOTIF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_MOTIF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTIF_GAP    = 2'd2;

    // Read classification reported with each result.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_FIRST  = 2'd1,
        STATUS_NO_SECOND = 2'd2,
        STATUS_BAD_GAP   = 2'd3
    } status_t;

    typedef struct packed {
        logic [MOTIF1_W-1:0] first_motif;
        logic [HIST_W-1:0]   second_motif;
        logic [GAP_W-1:0]    motif_gap;
    } amt_cfg_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] insert_length;
        logic [7:0] tag_start;
    } amt_result_t;

endpackage

@@ design/amt_cfg_regs.sv @@
module amt_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [amt_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [amt_pkg::CFG_DATA_W-1:0] wr_data,
    output amt_pkg::amt_cfg_t             cfg
);
    import amt_pkg::*;

    amt_cfg_t cfg_reg;
    amt_cfg_t cfg_next;

    // Decode the register index; indexes beyond the list are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_FIRST_MOTIF:  cfg_next.first_motif  = wr_data[MOTIF1_W-1:0];
                REG_SECOND_MOTIF: cfg_next.second_motif = wr_data[HIST_W-1:0];
                REG_MOTIF_GAP:    cfg_next.motif_gap    = wr_data[GAP_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_motif  <= FIRST_MOTIF_RST;
            cfg_reg.second_motif <= SECOND_MOTIF_RST;
            cfg_reg.motif_gap    <= MOTIF_GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/amt_matcher.sv @@
module amt_matcher #(
    parameter int MAX_READ_LEN = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  amt_pkg::amt_cfg_t    cfg,
    input  logic                 in_accept,
    input  logic [7:0]           in_base,
    input  logic                 in_last,
    output logic                 res_valid,
    output amt_pkg::amt_result_t res
);
    import amt_pkg::*;

    localparam int PW = $clog2(MAX_READ_LEN + 1);
    localparam int WW = (PW > 8) ? PW : 8;

    logic [PW-1:0]     position_reg, position_next;
    logic [HIST_W-1:0] history_reg, history_next;
    logic [2:0]        hist_cnt_reg, hist_cnt_next;
    logic              first_found_reg, first_found_next;
    logic [PW-1:0]     first_start_reg, first_start_next;
    logic              second_found_reg, second_found_next;
    logic [PW-1:0]     second_start_reg, second_start_next;

    logic          in_range;
    logic          hit1;
    logic          hit2;
    logic [PW-1:0] s2_start;
    logic [PW-1:0] first_end;
    logic [WW-1:0] tag_w;
    logic [WW-1:0] ins_w;
    logic [WW-1:0] spacing_w;

    // Shift in the new character and update the motif tracking state.
    always_comb begin
        position_next     = position_reg;
        history_next      = history_reg;
        hist_cnt_next     = hist_cnt_reg;
        first_found_next  = first_found_reg;
        first_start_next  = first_start_reg;
        second_found_next = second_found_reg;
        second_start_next = second_start_reg;
        hit1              = 1'b0;
        hit2              = 1'b0;
        in_range          = position_reg < PW'(MAX_READ_LEN);
        s2_start          = position_reg - PW'(MOTIF2_LEN - 1);

        if (in_accept && in_range) begin
            history_next  = {history_reg[HIST_W-9:0], in_base};
            hist_cnt_next = (hist_cnt_reg < 3'(MOTIF2_LEN)) ? hist_cnt_reg + 3'd1
                                                            : hist_cnt_reg;
            position_next = position_reg + PW'(1);

            // A new first motif restarts the search for the second one.
            hit1 = (hist_cnt_next >= 3'(MOTIF1_LEN)) &&
                   (history_next[MOTIF1_W-1:0] == cfg.first_motif);
            if (hit1) begin
                first_found_next  = 1'b1;
                first_start_next  = position_reg - PW'(MOTIF1_LEN - 1);
                second_found_next = 1'b0;
                second_start_next = '0;
            end

            // Keep only the earliest second motif past the first motif's end.
            hit2 = first_found_next && !second_found_next &&
                   (hist_cnt_next == 3'(MOTIF2_LEN)) &&
                   (history_next == cfg.second_motif) &&
                   (s2_start >= first_start_next + PW'(MOTIF1_LEN));
            if (hit2) begin
                second_found_next = 1'b1;
                second_start_next = s2_start;
            end
        end
    end

    // Classify the read from the state after the final character.
    always_comb begin
        first_end = first_start_next + PW'(MOTIF1_LEN);
        ins_w     = WW'(first_start_next);
        tag_w     = WW'(first_end);
        spacing_w = WW'(second_start_next - first_end);
        res_valid = in_accept && in_last;
        if (!first_found_next) begin
            res.status        = STATUS_NO_FIRST;
            res.insert_length = '0;
            res.tag_start     = '0;
        end else begin
            res.insert_length = ins_w[7:0];
            res.tag_start     = tag_w[7:0];
            if (!second_found_next) begin
                res.status = STATUS_NO_SECOND;
            end else if (spacing_w != WW'(cfg.motif_gap)) begin
                res.status = STATUS_BAD_GAP;
            end else begin
                res.status = STATUS_OK;
            end
        end
    end

    // The per-read state is cleared after the final character.
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_accept && in_last)) begin
            position_reg     <= '0;
            history_reg      <= '0;
            hist_cnt_reg     <= '0;
            first_found_reg  <= 1'b0;
            first_start_reg  <= '0;
            second_found_reg <= 1'b0;
            second_start_reg <= '0;
        end else begin
            position_reg     <= position_next;
            history_reg      <= history_next;
            hist_cnt_reg     <= hist_cnt_next;
            first_found_reg  <= first_found_next;
            first_start_reg  <= first_start_next;
            second_found_reg <= second_found_next;
            second_start_reg <= second_start_next;
        end
    end

endmodule

@@ design/amt_out_buf.sv @@
module amt_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  amt_pkg::amt_result_t push_data,
    output logic                 not_full,
    output logic                 out_valid,
    input  logic                 out_ready,
    output amt_pkg::amt_result_t out_data
);
    import amt_pkg::*;

    logic [1:0]  count_reg, count_next;
    amt_result_t slot0_reg, slot0_next;
    amt_result_t slot1_reg, slot1_next;
    logic        pop;

    assign out_valid = count_reg != 2'd0;
    assign not_full  = count_reg != 2'd2;
    assign out_data  = slot0_reg;
    assign pop       = out_valid && out_ready;

    // Two-entry buffer; slot 0 always holds the oldest result beat.
    always_comb begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop && !push) begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end else if (push && !pop) begin
            if (count_reg == 2'd0) begin
                slot0_next = push_data;
            end else begin
                slot1_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end else if (push && pop) begin
            if (count_reg == 2'd1) begin
                slot0_next = push_data;
            end else begin
                slot0_next = slot1_reg;
                slot1_next = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

@@ design/adaptor_motif_trimmer.sv @@
// Adaptor motif trimmer.
// The slave channel takes one read character per beat (s_tdata[7:0]) with
// s_tlast on the final character. Reads must not be empty. On the final
// beat one result beat leaves on the master channel: m_tuser carries the
// status, m_tdata the insert length and the tag start.
// Throughput is one character per cycle while s_tready is high: the history shift and
// both motif compares finish in the accepting cycle. With the buffer empty, the result
// appears on m_tvalid in the cycle after the final character is accepted.
// Results wait in a two-entry output buffer, so characters keep flowing while
// one result is pending; s_tready drops only when both entries are full.
// The cfg channel writes first_motif (0), second_motif (1) and motif_gap (2);
// cfg_ready is always high and writes belong between reads.
// Synchronous reset clears the per-read state and the buffer and reloads the
// default motifs and gap.
module adaptor_motif_trimmer #(
    parameter int MAX_READ_LEN = 128
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Read characters.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [7:0] base
    input  logic                           s_tlast,
    // Per-read results.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,  // [7:0] insert_length, [15:8] tag_start
    output logic [1:0]                     m_tuser,  // [1:0] status
    // Register writes.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [amt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [amt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import amt_pkg::*;

    amt_cfg_t    cfg;
    amt_result_t res;
    amt_result_t out_res;
    logic        res_valid;
    logic        in_accept;
    logic        buf_not_full;

    assign cfg_ready = 1'b1;
    assign s_tready  = buf_not_full;
    assign in_accept = s_tvalid && s_tready;

    amt_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    amt_matcher #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_base   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    amt_out_buf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .not_full  (buf_not_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tuser = out_res.status;
    assign m_tdata = {out_res.tag_start, out_res.insert_length};

endmodule
